/* design/ucdp_pkg.sv */
// Package for the USB configuration descriptor parser.
// Holds descriptor codes, record and queue entry types, and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucdp_pkg;

   localparam int MAX_INTERFACES_DEFAULT   = 4;
   localparam int MAX_IN_ENDPOINTS_DEFAULT = 4;
   localparam int BUFFER_BYTES_DEFAULT     = 512;

   localparam logic [7:0] TYPE_CONFIG    = 8'h02;
   localparam logic [7:0] TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
   localparam logic [7:0] CLASS_HID      = 8'h03;
   localparam logic [7:0] DIR_IN_MASK    = 8'h80;
   localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
   localparam logic [7:0] MIN_DESC_LEN   = 8'd2;

   // descriptor byte offsets of the fields picked out
   localparam logic [7:0] OFF_LENGTH     = 8'd0;
   localparam logic [7:0] OFF_TYPE       = 8'd1;
   localparam logic [7:0] OFF_NUM_IFS    = 8'd4;
   localparam logic [7:0] OFF_IF_CLASS   = 8'd5;
   localparam logic [7:0] OFF_EP_ADDR    = 8'd2;
   localparam logic [7:0] OFF_EP_MPS_LOW = 8'd4;
   localparam logic [7:0] OFF_EP_INTV    = 8'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_CONFIG = 2'd0,
      KIND_HID_IF = 2'd1,
      KIND_IN_EP  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_SHORT_DESC = 2'd1,
      ERR_SLOTS_FULL = 2'd2
   } error_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] interface_index;
      logic [2:0] endpoint_slot;
      logic [7:0] interface_count;
      logic [3:0] endpoint_number;
      logic [7:0] max_packet_low;
      logic [7:0] poll_interval;
      error_type  parse_error;
   } record_type;

   // one accepted byte gives at most a data record followed by a parse end record
   typedef struct packed {
      logic       data_valid;
      record_type data;
      logic       end_valid;
      error_type  end_error;
   } entry_type;

endpackage

`default_nettype wire

/* design/ucdp_req_if.sv */
// Input channel interface: one descriptor byte per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ucdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       first_byte;

   modport source (output valid, output desc_byte, output first_byte, input ready);
   modport sink   (input valid, input desc_byte, input first_byte, output ready);
endinterface

`default_nettype wire

/* design/ucdp_rsp_if.sv */
// Result channel interface: one parse record per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ucdp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] record_kind;
   logic [2:0] interface_index;
   logic [2:0] endpoint_slot;
   logic [7:0] interface_count;
   logic [3:0] endpoint_number;
   logic [7:0] max_packet_low;
   logic [7:0] poll_interval;
   logic [1:0] parse_error;
   logic       last_of_run;

   modport source (output valid, output record_kind, output interface_index,
                   output endpoint_slot, output interface_count, output endpoint_number,
                   output max_packet_low, output poll_interval, output parse_error,
                   output last_of_run, input ready);
   modport sink   (input valid, input record_kind, input interface_index,
                   input endpoint_slot, input interface_count, input endpoint_number,
                   input max_packet_low, input poll_interval, input parse_error,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

/* design/ucdp_front.sv */
// Front end: walks the descriptor chain one byte per transfer and builds queue entries.
// Depends on ucdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucdp_front #(
   parameter int MAX_INTERFACES   = ucdp_pkg::MAX_INTERFACES_DEFAULT,
   parameter int MAX_IN_ENDPOINTS = ucdp_pkg::MAX_IN_ENDPOINTS_DEFAULT,
   parameter int BUFFER_BYTES     = ucdp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_first,
   output logic                     in_ready,
   input  wire logic                queue_full,
   output logic                     push,
   output ucdp_pkg::entry_type      push_entry
);

   localparam int POS_W  = $clog2(BUFFER_BYTES);
   localparam int ICNT_W = $clog2(MAX_INTERFACES + 1);
   localparam int ECNT_W = $clog2(MAX_IN_ENDPOINTS + 1);

   logic [POS_W-1:0]  pos_ff,   pos_in,   cur_pos;
   logic [15:0]       total_ff, total_in, cur_total;
   logic [7:0]        off_ff,   off_in,   cur_off;
   logic [7:0]        dlen_ff,  dlen_in,  cur_dlen;
   logic [7:0]        dtype_ff, dtype_in, cur_dtype;
   logic              hid_ff,   hid_in,   cur_hid;
   logic [ICNT_W-1:0] icnt_ff,  icnt_in,  cur_icnt;
   logic [ECNT_W-1:0] ecnt_ff,  ecnt_in,  cur_ecnt;
   logic [7:0]        addr_ff,  addr_in,  cur_addr;
   logic [7:0]        mps_ff,   mps_in,   cur_mps;
   logic              stop_ff,  stop_in,  cur_stop;

   logic       accept;
   logic       halt;
   logic [7:0] start;
   logic [2:0] ifx;
   ucdp_pkg::entry_type entry;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && (entry.data_valid || entry.end_valid);
   assign push_entry = entry;

   always_comb begin
      // a first byte parses from the reset state
      if (in_first) begin
         cur_pos   = '0;
         cur_total = 16'hFFFF;
         cur_off   = '0;
         cur_dlen  = '0;
         cur_dtype = '0;
         cur_hid   = 1'b0;
         cur_icnt  = '0;
         cur_ecnt  = '0;
         cur_addr  = '0;
         cur_mps   = '0;
         cur_stop  = 1'b0;
      end else begin
         cur_pos   = pos_ff;
         cur_total = total_ff;
         cur_off   = off_ff;
         cur_dlen  = dlen_ff;
         cur_dtype = dtype_ff;
         cur_hid   = hid_ff;
         cur_icnt  = icnt_ff;
         cur_ecnt  = ecnt_ff;
         cur_addr  = addr_ff;
         cur_mps   = mps_ff;
         cur_stop  = stop_ff;
      end

      pos_in   = cur_pos;
      total_in = cur_total;
      off_in   = cur_off;
      dlen_in  = cur_dlen;
      dtype_in = cur_dtype;
      hid_in   = cur_hid;
      icnt_in  = cur_icnt;
      ecnt_in  = cur_ecnt;
      addr_in  = cur_addr;
      mps_in   = cur_mps;
      stop_in  = cur_stop;

      entry = '0;
      halt  = 1'b0;
      start = (cur_off <= 8'd3) ? 8'd3 - cur_off : 8'd0;
      ifx   = 3'(cur_icnt - 1'b1);

      if (!cur_stop) begin
         if (cur_pos == POS_W'(2)) begin
            total_in[7:0] = in_byte;
         end
         if (cur_pos == POS_W'(3)) begin
            total_in[15:8] = in_byte;
            // total length already behind the descriptor in progress
            if ({8'h00, start} >= total_in) begin
               entry.end_valid = 1'b1;
               halt = 1'b1;
            end
         end

         if (!halt) begin
            if (cur_off == ucdp_pkg::OFF_LENGTH) begin
               dlen_in = in_byte;
               if (in_byte < ucdp_pkg::MIN_DESC_LEN) begin
                  entry.end_valid = 1'b1;
                  entry.end_error = ucdp_pkg::ERR_SHORT_DESC;
                  halt = 1'b1;
               end
            end else if (cur_off == ucdp_pkg::OFF_TYPE) begin
               dtype_in = in_byte;
               if (in_byte == ucdp_pkg::TYPE_INTERFACE) begin
                  hid_in = 1'b0;
                  if (cur_icnt >= ICNT_W'(MAX_INTERFACES)) begin
                     entry.end_valid = 1'b1;
                     halt = 1'b1;
                  end else begin
                     icnt_in = cur_icnt + 1'b1;
                  end
               end
            end else if (cur_dtype == ucdp_pkg::TYPE_CONFIG) begin
               // header is skipped for a config descriptor inside a HID interface
               if (cur_off == ucdp_pkg::OFF_NUM_IFS && !cur_hid) begin
                  entry.data_valid           = 1'b1;
                  entry.data.kind            = ucdp_pkg::KIND_CONFIG;
                  entry.data.interface_count = in_byte;
               end
            end else if (cur_dtype == ucdp_pkg::TYPE_INTERFACE) begin
               if (cur_off == ucdp_pkg::OFF_IF_CLASS && in_byte == ucdp_pkg::CLASS_HID) begin
                  hid_in  = 1'b1;
                  ecnt_in = '0;
                  entry.data_valid           = 1'b1;
                  entry.data.kind            = ucdp_pkg::KIND_HID_IF;
                  entry.data.interface_index = ifx;
               end
            end else if (cur_dtype == ucdp_pkg::TYPE_ENDPOINT && cur_hid) begin
               if (cur_off == ucdp_pkg::OFF_EP_ADDR) begin
                  addr_in = in_byte;
               end else if (cur_off == ucdp_pkg::OFF_EP_MPS_LOW) begin
                  mps_in = in_byte;
               end else if (cur_off == ucdp_pkg::OFF_EP_INTV
                            && (cur_addr & ucdp_pkg::DIR_IN_MASK) != 8'h00) begin
                  entry.data_valid           = 1'b1;
                  entry.data.kind            = ucdp_pkg::KIND_IN_EP;
                  entry.data.interface_index = ifx;
                  if (cur_ecnt < ECNT_W'(MAX_IN_ENDPOINTS)) begin
                     entry.data.endpoint_slot   = 3'(cur_ecnt);
                     entry.data.endpoint_number = 4'(cur_addr & ucdp_pkg::EP_NUM_MASK);
                     entry.data.max_packet_low  = cur_mps;
                     entry.data.poll_interval   = in_byte;
                     ecnt_in = cur_ecnt + 1'b1;
                  end else begin
                     entry.data.parse_error = ucdp_pkg::ERR_SLOTS_FULL;
                  end
               end
            end
         end

         if (!halt) begin
            if ({1'b0, cur_off} + 9'd1 >= {1'b0, dlen_in}) begin
               off_in = '0;
               if (17'(cur_pos) + 17'd1 >= {1'b0, total_in}) begin
                  entry.end_valid = 1'b1;
               end
            end else begin
               off_in = cur_off + 8'd1;
            end
            pos_in = cur_pos + 1'b1;
            // last byte the buffer can hold
            if (!entry.end_valid && 17'(cur_pos) + 17'd1 >= 17'(BUFFER_BYTES)) begin
               entry.end_valid = 1'b1;
            end
         end

         if (entry.end_valid) begin
            stop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= 16'hFFFF;
         off_ff   <= '0;
         dlen_ff  <= '0;
         dtype_ff <= '0;
         hid_ff   <= 1'b0;
         icnt_ff  <= '0;
         ecnt_ff  <= '0;
         addr_ff  <= '0;
         mps_ff   <= '0;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         off_ff   <= off_in;
         dlen_ff  <= dlen_in;
         dtype_ff <= dtype_in;
         hid_ff   <= hid_in;
         icnt_ff  <= icnt_in;
         ecnt_ff  <= ecnt_in;
         addr_ff  <= addr_in;
         mps_ff   <= mps_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

`default_nettype wire

/* design/ucdp_queue.sv */
// Short queue of parse entries between the front end and the output stage.
// Depends on ucdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucdp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ucdp_pkg::entry_type push_entry,
   input  wire logic                pop,
   output ucdp_pkg::entry_type      head,
   output logic                     empty,
   output logic                     full
);

   localparam int PW = ucdp_pkg::QUEUE_PTR_W;

   ucdp_pkg::entry_type mem_ff [ucdp_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff,  count_in;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PW+1)'(ucdp_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* design/ucdp_back.sv */
// Output stage: sends the records of the head queue entry one per transfer.
// Depends on ucdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucdp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ucdp_pkg::entry_type head,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ucdp_pkg::record_type     out_record,
   output logic                     out_last
);

   // set once the data record of a two-record entry has gone
   logic data_sent_ff, data_sent_in;
   logic send_data;
   logic xfer;

   assign out_valid = !empty;
   assign send_data = head.data_valid && !data_sent_ff;
   assign xfer      = out_valid && out_ready;
   assign pop       = xfer && out_last;

   always_comb begin
      if (send_data) begin
         out_record = head.data;
         out_last   = !head.end_valid;
      end else begin
         out_record             = '0;
         out_record.kind        = ucdp_pkg::KIND_END;
         out_record.parse_error = head.end_error;
         out_last               = 1'b1;
      end

      data_sent_in = data_sent_ff;
      if (pop) begin
         data_sent_in = 1'b0;
      end else if (xfer && send_data) begin
         data_sent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_sent_ff <= 1'b0;
      end else begin
         data_sent_ff <= data_sent_in;
      end
   end

endmodule

`default_nettype wire

/* design/usb_config_descriptor_parser.sv */
// USB configuration descriptor parser. Takes the descriptor buffer one byte per
// transfer on req_stream (first_byte restarts the walk) and returns header, HID
// interface, IN endpoint and parse end records on rsp_stream. A byte is taken
// every cycle while the four-entry record queue has room; a byte that yields
// two records (a data record and the parse end) takes two output transfers,
// and the sustained rate is one byte per cycle with rsp_stream ready.
// A byte's records are registered in the record queue before rsp_stream. Bytes
// after the parse end are taken and give nothing until the next first byte.
// Depends on ucdp_pkg, ucdp_req_if, ucdp_rsp_if, ucdp_front, ucdp_queue, ucdp_back.
`timescale 1ns / 1ps
`default_nettype none

module usb_config_descriptor_parser #(
   parameter int MAX_INTERFACES   = ucdp_pkg::MAX_INTERFACES_DEFAULT,
   parameter int MAX_IN_ENDPOINTS = ucdp_pkg::MAX_IN_ENDPOINTS_DEFAULT,
   parameter int BUFFER_BYTES     = ucdp_pkg::BUFFER_BYTES_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   ucdp_req_if.sink   req_stream,
   ucdp_rsp_if.source rsp_stream
);

   logic                 push;
   logic                 pop;
   logic                 empty;
   logic                 full;
   logic                 front_ready;
   logic                 out_valid;
   logic                 out_last;
   ucdp_pkg::entry_type  push_entry;
   ucdp_pkg::entry_type  head;
   ucdp_pkg::record_type out_record;

   ucdp_front #(
      .MAX_INTERFACES   (MAX_INTERFACES),
      .MAX_IN_ENDPOINTS (MAX_IN_ENDPOINTS),
      .BUFFER_BYTES     (BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_stream.valid),
      .in_byte    (req_stream.desc_byte),
      .in_first   (req_stream.first_byte),
      .in_ready   (front_ready),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   ucdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ucdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .out_valid  (out_valid),
      .out_ready  (rsp_stream.ready),
      .out_record (out_record),
      .out_last   (out_last)
   );

   assign req_stream.ready           = front_ready;
   assign rsp_stream.valid           = out_valid;
   assign rsp_stream.record_kind     = out_record.kind;
   assign rsp_stream.interface_index = out_record.interface_index;
   assign rsp_stream.endpoint_slot   = out_record.endpoint_slot;
   assign rsp_stream.interface_count = out_record.interface_count;
   assign rsp_stream.endpoint_number = out_record.endpoint_number;
   assign rsp_stream.max_packet_low  = out_record.max_packet_low;
   assign rsp_stream.poll_interval   = out_record.poll_interval;
   assign rsp_stream.parse_error     = out_record.parse_error;
   assign rsp_stream.last_of_run     = out_last;

endmodule

`default_nettype wire
